// ----- rtl/ultrasonic_echo_ranger_defines.svh -----
// Assertion macros used by the checker file uer_checker.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UER_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uer check failed");

`endif

// ----- rtl/uer_pkg.sv -----
`timescale 1ns / 1ps

package uer_pkg;

    localparam int unsigned TIMEOUT_W = 10;
    localparam int unsigned COUNT_W   = 10;
    localparam int unsigned DIST_W    = 11;
    localparam int unsigned SENSOR_W  = 2;
    localparam int unsigned LINES_W   = 3;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 10'd300;

    localparam logic                CMD_TICK       = 1'b0;
    localparam logic                CMD_START      = 1'b1;
    localparam logic [SENSOR_W-1:0] SENSOR_INVALID = 2'd3;

    // Echo width to centimetres: (w * CM_MUL + CM_ROUND) / CM_DIV.
    // The divide is a multiply by ceil(2^31 / 1000) and a shift; the reciprocal
    // error (352) stays under 2^(31-21), so the quotient is exact for every
    // dividend below 2^21, which covers all 10-bit widths.
    localparam int unsigned CM_MUL      = 1715;
    localparam int unsigned CM_ROUND    = 500;
    localparam int unsigned CM_DIV      = 1000;
    localparam int unsigned RECIP_SHIFT = 31;
    localparam logic [63:0] CM_RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(CM_DIV) - 64'd1) / 64'(CM_DIV);
    localparam logic [63:0] CM_SCALE  = 64'(CM_MUL) * CM_RECIP;
    localparam logic [63:0] CM_OFFSET = 64'(CM_ROUND) * CM_RECIP;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TRIG_LOW  = 3'd1,
        PH_TRIG_HIGH = 3'd2,
        PH_WAIT_HIGH = 3'd3,
        PH_WAIT_LOW  = 3'd4
    } phase_t;

    typedef struct packed {
        logic                cmd;
        logic [SENSOR_W-1:0] sensor;
        logic [LINES_W-1:0]  echo_lines;
    } item_t;

    typedef struct packed {
        logic [LINES_W-1:0] trig_lines;
        logic               busy_res;
        logic               done_res;
        logic               ok;
        logic [DIST_W-1:0]  range_cm;
    } result_t;

endpackage

// ----- rtl/ultrasonic_echo_ranger.sv -----
`timescale 1ns / 1ps

// Ultrasonic echo ranger for three sensors (front, left, right). Every input
// transaction is either a 100 us tick or a start; each one yields exactly one
// result transaction carrying trigger levels, busy, done, ok and the distance
// in centimetres. A start while idle picks a sensor (code 3 ends at once with
// done and not ok); the following ticks pulse that sensor's trigger and then time its
// echo, and each edge wait fails after cfg_data ticks (echo_timeout, reset 300,
// written through the cfg channel; the user must write it only while no
// measurement is running, and the block does not enforce this). The block
// sustains one transaction per clock while results are drained; a result
// becomes valid after passing an input register and a result register, and
// the path between them is the state update plus one constant multiply that
// turns the echo width into centimetres. A new item is still taken while a
// result waits, as long as the input register is empty; with both registers
// full, item_ready drops until the result is drained.

module ultrasonic_echo_ranger
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          item_valid,
    output logic                          item_ready,
    input  uer_pkg::item_t                item,

    output logic                          result_valid,
    input  logic                          result_ready,
    output uer_pkg::result_t              result,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [uer_pkg::TIMEOUT_W-1:0] cfg_data
);

    // Input stage: holds one accepted transaction until the core consumes it.
    logic                          hold_valid_reg, hold_valid_next;
    uer_pkg::item_t                hold_item_reg;

    // Result stage.
    logic                          result_valid_reg, result_valid_next;
    uer_pkg::result_t              result_reg;
    uer_pkg::result_t              core_result;

    logic [uer_pkg::TIMEOUT_W-1:0] timeout_reg;

    logic                          advance;
    logic                          fire;

    // Advance when the result slot is empty or being drained this cycle.
    assign advance    = !result_valid_reg || result_ready;
    assign fire       = hold_valid_reg && advance;
    assign item_ready = !hold_valid_reg || advance;
    assign cfg_ready  = 1'b1;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    uer_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (hold_item_reg),
        .timeout (timeout_reg),
        .result  (core_result)
    );

    always_comb
    begin
        // Keep the input slot full while a new transaction arrives or the old one waits.
        hold_valid_next = (item_valid && item_ready) || (hold_valid_reg && !advance);
        // Keep the result slot full when the core fires or the old result is not taken.
        result_valid_next = fire || (result_valid_reg && !result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            timeout_reg      <= uer_pkg::TIMEOUT_RESET;
        end
        else
        begin
            hold_valid_reg   <= hold_valid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    // Payload registers: load on transfer, no reset needed.
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            hold_item_reg <= item;
        end
        if (fire)
        begin
            result_reg <= core_result;
        end
    end

endmodule

// ----- rtl/uer_range.sv -----
`timescale 1ns / 1ps

module uer_range
(
    input  logic [uer_pkg::COUNT_W-1:0] width_ticks,
    output logic [uer_pkg::DIST_W-1:0]  cm_out
);

    localparam int unsigned PROD_W = 42;

    logic [PROD_W-1:0] scaled;

    // Scale and round in one constant multiply, then drop the reciprocal's fraction.
    assign scaled = PROD_W'(width_ticks) * PROD_W'(uer_pkg::CM_SCALE)
                  + PROD_W'(uer_pkg::CM_OFFSET);

    assign cm_out =
        scaled[uer_pkg::RECIP_SHIFT + uer_pkg::DIST_W - 1 : uer_pkg::RECIP_SHIFT];

endmodule

// ----- rtl/uer_core.sv -----
`timescale 1ns / 1ps

module uer_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  uer_pkg::item_t                item,
    input  logic [uer_pkg::TIMEOUT_W-1:0] timeout,
    output uer_pkg::result_t              result
);

    uer_pkg::phase_t               phase_reg,  phase_next;
    logic [uer_pkg::SENSOR_W-1:0]  sensor_reg, sensor_next;
    logic [uer_pkg::COUNT_W-1:0]   count_reg,  count_next;

    logic                          is_start;
    logic                          level;
    logic                          timed_out;
    logic [uer_pkg::COUNT_W-1:0]   count_inc;
    logic [uer_pkg::LINES_W-1:0]   trig_bit;
    logic [uer_pkg::DIST_W-1:0]    cm_value;

    assign is_start  = (item.cmd == uer_pkg::CMD_START);
    assign level     = item.echo_lines[sensor_reg];
    assign count_inc = count_reg + uer_pkg::COUNT_W'(1);
    assign timed_out = (count_inc >= timeout);
    assign trig_bit  = uer_pkg::LINES_W'(1) << sensor_reg;

    uer_range u_range
    (
        .width_ticks (count_inc),
        .cm_out      (cm_value)
    );

    always_comb
    begin
        phase_next  = phase_reg;
        sensor_next = sensor_reg;
        count_next  = count_reg;
        if (is_start)
        begin
            if (phase_reg == uer_pkg::PH_IDLE && item.sensor != uer_pkg::SENSOR_INVALID)
            begin
                sensor_next = item.sensor;
                count_next  = '0;
                phase_next  = uer_pkg::PH_TRIG_LOW;
            end
        end
        else
        begin
            unique case (phase_reg)
                uer_pkg::PH_IDLE:
                begin
                end
                uer_pkg::PH_TRIG_LOW:
                begin
                    phase_next = uer_pkg::PH_TRIG_HIGH;
                end
                uer_pkg::PH_TRIG_HIGH:
                begin
                    phase_next = uer_pkg::PH_WAIT_HIGH;
                    count_next = '0;
                end
                uer_pkg::PH_WAIT_HIGH:
                begin
                    count_next = count_inc;
                    if (level)
                    begin
                        phase_next = uer_pkg::PH_WAIT_LOW;
                        count_next = '0;
                    end
                    else if (timed_out)
                    begin
                        phase_next = uer_pkg::PH_IDLE;
                    end
                end
                uer_pkg::PH_WAIT_LOW:
                begin
                    count_next = count_inc;
                    if (!level || timed_out)
                    begin
                        phase_next = uer_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = uer_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        result          = '0;
        result.busy_res = (phase_next != uer_pkg::PH_IDLE);
        if (is_start)
        begin
            result.done_res = (phase_reg == uer_pkg::PH_IDLE)
                           && (item.sensor == uer_pkg::SENSOR_INVALID);
        end
        else
        begin
            unique case (phase_reg)
                uer_pkg::PH_IDLE,
                uer_pkg::PH_TRIG_HIGH:
                begin
                end
                uer_pkg::PH_TRIG_LOW:
                begin
                    result.trig_lines = trig_bit;
                end
                uer_pkg::PH_WAIT_HIGH:
                begin
                    result.done_res = !level && timed_out;
                end
                uer_pkg::PH_WAIT_LOW:
                begin
                    result.done_res = !level || timed_out;
                    result.ok       = !level;
                    if (!level)
                    begin
                        result.range_cm = cm_value;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= uer_pkg::PH_IDLE;
            sensor_reg <= '0;
            count_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            sensor_reg <= sensor_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/uer_checker.sv -----
`timescale 1ns / 1ps

`include "ultrasonic_echo_ranger_defines.svh"

module uer_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input uer_pkg::result_t result
);

    // After every accepted transaction, result_valid is high by the time the input and result registers are passed.
    `UER_ASSERT_IMPLIES(a_accept_to_result, clk, rst_n, item_valid && item_ready, ##2 result_valid)

    // At most one sensor's trigger may be driven.
    `UER_ASSERT_IMPLIES(a_trig_onehot, clk, rst_n, result_valid, $onehot0(result.trig_lines))

    // A finished measurement leaves the ranger idle.
    `UER_ASSERT_IMPLIES(a_done_not_busy, clk, rst_n, result_valid && result.done_res, !result.busy_res)

    // Hold a stalled result unchanged.
    `UER_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result))

endmodule

bind ultrasonic_echo_ranger uer_checker u_checker (.*);

// ----- tb/echo_ranger_checker.sv -----
`timescale 1ns / 1ps

module echo_ranger_checker
    import uer_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   item_valid,
    input  logic                   item_ready,
    input  item_t                  item,

    input  logic                   result_valid,
    input  logic                   result_ready,
    input  result_t                result,

    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [TIMEOUT_W-1:0]   cfg_data,

    output int                     mismatches,
    output int                     outstanding,
    output int                     results_seen,
    output int                     readings_ok,
    output int                     readings_failed
);

    // Shadow of the ranger state.
    phase_t                ph;
    logic [SENSOR_W-1:0]   sel_sensor;
    logic [COUNT_W-1:0]    ticks;
    logic [TIMEOUT_W-1:0]  timeout;

    result_t               due_readings[$];

    task automatic predict_reading(input item_t it, output result_t r);
        logic        lvl;
        int unsigned w;
        r = '0;
        if (it.cmd == CMD_START)
        begin
            if (ph == PH_IDLE)
            begin
                if (it.sensor == SENSOR_INVALID)
                begin
                    r.done_res = 1'b1;
                end
                else
                begin
                    sel_sensor = it.sensor;
                    ticks      = '0;
                    ph         = PH_TRIG_LOW;
                end
            end
        end
        else
        begin
            lvl = it.echo_lines[sel_sensor];
            case (ph)
                PH_TRIG_LOW:
                begin
                    ph           = PH_TRIG_HIGH;
                    r.trig_lines = 3'b001 << sel_sensor;
                end
                PH_TRIG_HIGH:
                begin
                    ph    = PH_WAIT_HIGH;
                    ticks = '0;
                end
                PH_WAIT_HIGH:
                begin
                    ticks = ticks + COUNT_W'(1);
                    if (lvl)
                    begin
                        ph    = PH_WAIT_LOW;
                        ticks = '0;
                    end
                    else if (ticks >= timeout)
                    begin
                        ph         = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                end
                PH_WAIT_LOW:
                begin
                    ticks = ticks + COUNT_W'(1);
                    if (!lvl)
                    begin
                        ph         = PH_IDLE;
                        r.done_res = 1'b1;
                        r.ok       = 1'b1;
                        w          = 32'(ticks);
                        r.range_cm = DIST_W'((w * CM_MUL + CM_ROUND) / CM_DIV);
                    end
                    else if (ticks >= timeout)
                    begin
                        ph         = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                end
                default:
                begin
                    ph = PH_IDLE;
                end
            endcase
        end
        r.busy_res = (ph != PH_IDLE);
    endtask

    task automatic flag_field(input string field, input logic [15:0] want_v,
                              input logic [15:0] got_v);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            ph              = PH_IDLE;
            sel_sensor      = '0;
            ticks           = '0;
            timeout         = TIMEOUT_RESET;
            mismatches      = 0;
            results_seen    = 0;
            readings_ok     = 0;
            readings_failed = 0;
            due_readings.delete();
            outstanding    <= 0;
        end
        else
        begin
            // Retire before predicting so a stray result cannot match a fresh item.
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (due_readings.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h", $time, result);
                    mismatches++;
                end
                else
                begin
                    want = due_readings.pop_front();
                    if (result.trig_lines !== want.trig_lines)
                        flag_field("trig_lines", 16'(want.trig_lines), 16'(result.trig_lines));
                    if (result.busy_res !== want.busy_res)
                        flag_field("busy_res", 16'(want.busy_res), 16'(result.busy_res));
                    if (result.done_res !== want.done_res)
                        flag_field("done_res", 16'(want.done_res), 16'(result.done_res));
                    if (result.ok !== want.ok)
                        flag_field("ok", 16'(want.ok), 16'(result.ok));
                    if (result.range_cm !== want.range_cm)
                        flag_field("range_cm", 16'(want.range_cm), 16'(result.range_cm));
                    if (want.done_res && want.ok)
                        readings_ok++;
                    else if (want.done_res)
                        readings_failed++;
                end
            end
            if (cfg_valid && cfg_ready)
                timeout = cfg_data;
            if (item_valid && item_ready)
            begin
                predict_reading(item, want);
                due_readings.push_back(want);
            end
            outstanding <= due_readings.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import uer_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
    localparam int HOLD_OFF       = 64;    // long receiver stall, in cycles
    localparam int PHASE_ITEMS    = 100;   // random transactions per idle profile
    localparam int LONG_WIDTH     = 250;   // echo width of the long measurement

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    item_t                 item;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [TIMEOUT_W-1:0]  cfg_data;

    int mismatches;
    int outstanding;
    int results_seen;
    int readings_ok;
    int readings_failed;

    // Idle rates in percent, shared between the stimulus and the ready process.
    int sender_idle;
    int receiver_idle;
    int stall_asks;
    int items_sent;
    int idle_cycles;
    logic [TIMEOUT_W-1:0] cur_timeout;

    ultrasonic_echo_ranger dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    echo_ranger_checker watch
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .item            (item),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_seen    (results_seen),
        .readings_ok     (readings_ok),
        .readings_failed (readings_failed)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result-side ready. A stall request from the stimulus holds ready low for a
    // stall counted out here, while the sender keeps offering items so the block
    // fills up and has to push back on its input.
    initial
    begin
        int served;
        served = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_asks != served)
            begin
                served++;
                repeat (HOLD_OFF)
                begin
                    result_ready <= 1'b0;
                    @(posedge clk);
                end
            end
            result_ready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    // Watchdog: end the run if no transaction of any kind moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAIL ultrasonic_echo_ranger");
                $finish;
            end
        end
    end

    function automatic item_t tick_item(input logic [LINES_W-1:0] echo);
        item_t it;
        it.cmd        = CMD_TICK;
        it.sensor     = SENSOR_W'($urandom);  // don't-care on a tick, so scramble it
        it.echo_lines = echo;
        return it;
    endfunction

    function automatic item_t start_item(input logic [SENSOR_W-1:0] s);
        item_t it;
        it.cmd        = CMD_START;
        it.sensor     = s;
        it.echo_lines = LINES_W'($urandom);
        return it;
    endfunction

    // Random echo lines with the chosen sensor's line forced to lvl.
    function automatic logic [LINES_W-1:0] echo_with(input logic [SENSOR_W-1:0] s,
                                                     input logic lvl);
        logic [LINES_W-1:0] e;
        e = LINES_W'($urandom);
        if (s != SENSOR_INVALID)
            e[s] = lvl;
        return e;
    endfunction

    // Offer one input transaction and hold it until accepted. Valid stays high
    // on return; whoever pauses next has to drop it.
    task automatic offer_item(input item_t it);
        while ($urandom_range(99) < sender_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and hold off until every predicted result has come back.
    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Timeout writes only go in with the pipeline empty, after a short settle.
    task automatic write_timeout(input logic [TIMEOUT_W-1:0] v);
        wait_drained();
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        cur_timeout  = v;
    endtask

    // One well-formed measurement: start, the two trigger ticks, rise low
    // ticks, an echo high for width ticks, then one low tick. Busy starts may be
    // sprinkled into the wait so the block has to ignore them.
    task automatic run_measurement(input logic [SENSOR_W-1:0] s, input int rise,
                                   input int width, input int noise_pct);
        int k;
        offer_item(start_item(s));
        repeat (2) offer_item(tick_item(LINES_W'($urandom)));
        for (k = 0; k < rise + width + 1; k++)
        begin
            if ($urandom_range(99) < noise_pct)
                offer_item(start_item(SENSOR_W'($urandom)));
            offer_item(tick_item(echo_with(s, (k >= rise) && (k < rise + width))));
        end
    endtask

    function automatic logic [TIMEOUT_W-1:0] pick_timeout();
        case ($urandom_range(5))
            0:       return 10'd1;
            1:       return 10'd1023;
            2:       return 10'd0;
            default: return TIMEOUT_W'($urandom_range(2, 40));
        endcase
    endfunction

    task automatic random_phase(input int s_idle, input int r_idle, input int n_items,
                                input bit with_stall);
        int stop_at;
        int pick;
        int lim;
        logic [SENSOR_W-1:0] s;
        sender_idle   = s_idle;
        receiver_idle = r_idle;
        stop_at       = items_sent + n_items;
        if (with_stall)
            stall_asks <= stall_asks + 1;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
            begin
                write_timeout(pick_timeout());
            end
            else if (pick < 8)
            begin
                wait_drained();
            end
            else if (pick < 88)
            begin
                // Keep waits short even with a long timeout; some exceed it.
                lim = (cur_timeout < 40) ? int'(cur_timeout) : 40;
                s   = ($urandom_range(15) == 0) ? SENSOR_INVALID
                                                : SENSOR_W'($urandom_range(2));
                run_measurement(s, $urandom_range(lim + 1), $urandom_range(1, lim + 2), 8);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    offer_item(item_t'($bits(item_t)'($urandom)));
            end
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        item_valid  <= 1'b0;
        item        <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        stall_asks  <= 0;
        items_sent    = 0;
        sender_idle   = 14;
        receiver_idle = 68;
        cur_timeout   = TIMEOUT_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tick while idle, then an invalid sensor that ends at once.
        offer_item(tick_item(3'b111));
        offer_item(start_item(SENSOR_INVALID));
        // Front sensor, a start while busy, and a one-tick echo.
        offer_item(start_item(2'd0));
        offer_item(tick_item(3'b111));
        offer_item(start_item(2'd2));
        offer_item(tick_item(3'b000));
        offer_item(tick_item(3'b001));
        offer_item(tick_item(3'b110));
        // Left sensor: drop the timeout to 2 while the rise wait is at 2 ticks,
        // so the very next tick gives up.
        offer_item(start_item(2'd1));
        offer_item(tick_item(3'b000));
        offer_item(tick_item(3'b000));
        offer_item(tick_item(3'b101));
        offer_item(tick_item(3'b000));
        write_timeout(10'd2);
        offer_item(tick_item(3'b101));
        // Zero timeout: a missing rise fails at once, and so does a held echo.
        write_timeout(10'd0);
        offer_item(start_item(2'd2));
        offer_item(tick_item(3'b111));
        offer_item(tick_item(3'b000));
        offer_item(tick_item(3'b011));
        offer_item(start_item(2'd2));
        offer_item(tick_item(3'b000));
        offer_item(tick_item(3'b111));
        offer_item(tick_item(3'b100));
        offer_item(tick_item(3'b111));

        // Random: back to the reset value first, then three idle profiles.
        write_timeout(TIMEOUT_RESET);
        random_phase(14, 68, PHASE_ITEMS, 1'b0);
        write_timeout(10'd1);
        random_phase(68, 14, PHASE_ITEMS, 1'b0);
        write_timeout(TIMEOUT_W'($urandom_range(2, 40)));
        random_phase(0, 0, PHASE_ITEMS, 1'b1);

        // A long echo at the largest timeout.
        write_timeout(10'd1023);
        run_measurement(2'd0, 5, LONG_WIDTH, 0);

        wait_drained();
        repeat (8) @(posedge clk);

        $display("Ran %0d transactions, %0d results: %0d readings, %0d ended without one.",
                 items_sent, results_seen, readings_ok, readings_failed);
        $display("Timeouts 0, 1, 2, 300 and 1023 plus a change mid-wait; three idle profiles.");
        if (mismatches == 0 && outstanding == 0)
            $display("PASS ultrasonic_echo_ranger");
        else
            $display("FAIL ultrasonic_echo_ranger");
        $finish;
    end

endmodule

// ----- ultrasonic_echo_ranger.f -----
+incdir+rtl
rtl/uer_pkg.sv
rtl/uer_range.sv
rtl/uer_core.sv
rtl/ultrasonic_echo_ranger.sv
rtl/uer_checker.sv
tb/echo_ranger_checker.sv
tb/testbench.sv
